// File: hdl/timed_tone_queue_scheduler_top_assert.svh
// ----------------------------------------------------------------------------
// Timed tone queue scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler modules.
// ----------------------------------------------------------------------------
`ifndef TIMED_TONE_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define TIMED_TONE_QUEUE_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TTQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TTQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ttqs_pkg.sv
// ----------------------------------------------------------------------------
// Timed tone queue scheduler package
// Shared types, codes and constants of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ttqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 4096;

	localparam int FREQ_W = 16;
	localparam int MS_W   = 16;
	localparam int VOL_W  = 7;
	localparam int TIME_W = 48;
	localparam int TICK_W = 24;
	localparam int GAIN_W = 9;
	localparam int AMP_W  = 15;
	localparam int SPAN_W = MS_W + TICK_W;
	localparam int PROD_W = VOL_W + GAIN_W;

	localparam logic [TICK_W-1:0] TICKS_RESET = TICK_W'(1000);
	localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(160);
	localparam logic [AMP_W-1:0]  AMP_MAX     = '1;

	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_SVC = 2'd1;
	localparam logic [1:0] MODE_CLR = 2'd2;

	localparam logic REG_TICKS = 1'b0;
	localparam logic REG_GAIN  = 1'b1;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_SVC = 2'd1,
		OP_CLR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_PAUSE = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_DROP  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [MS_W-1:0]   ms;
		logic [VOL_W-1:0]  vol;
	} tone_t;

	typedef struct packed {
		op_t               op;
		tone_t             tone;
		logic [TIME_W-1:0] now;
	} item_t;

endpackage

`default_nettype wire

// File: hdl/ttqs_ram.sv
// ----------------------------------------------------------------------------
// Timed tone queue scheduler RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/ttqs_front.sv
// ----------------------------------------------------------------------------
// Timed tone queue scheduler front end
// Accepts input beats, decodes the mode and buffers work in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ttqs_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [1:0]                    mode,
	input  wire logic [ttqs_pkg::FREQ_W-1:0]   tone_freq,
	input  wire logic [ttqs_pkg::MS_W-1:0]     tone_ms,
	input  wire logic [ttqs_pkg::VOL_W-1:0]    tone_vol,
	input  wire logic [ttqs_pkg::TIME_W-1:0]   now,
	output logic                               q_valid,
	input  wire logic                          q_ready,
	output ttqs_pkg::item_t                    q_item
);

	import ttqs_pkg::*;

	`include "timed_tone_queue_scheduler_top_assert.svh"

	localparam int FIFO_DEPTH = 2;

	item_t      fifo_q [FIFO_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      dec_item;
	logic       dec_keep;
	logic       push;
	logic       pop;

	always_comb begin
		dec_keep           = 1'b1;
		dec_item.tone.freq = tone_freq;
		dec_item.tone.ms   = tone_ms;
		dec_item.tone.vol  = tone_vol;
		dec_item.now       = now;
		dec_item.op        = OP_ENQ;
		unique case (mode)
			MODE_ENQ: dec_item.op = OP_ENQ;
			MODE_SVC: dec_item.op = OP_SVC;
			MODE_CLR: dec_item.op = OP_CLR;
			default:  dec_keep    = 1'b0;
		endcase
	end

	assign item_ready = (cnt_q != 2'(FIFO_DEPTH));
	assign push       = item_valid && item_ready && dec_keep;
	assign q_valid    = (cnt_q != 2'd0);
	assign pop        = q_valid && q_ready;
	assign q_item     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec_item;
		end
	end

	`TTQS_ASSERT_NXT(a_push_visible, clk, arst_n, push, q_valid,
		"front: a queued beat is not visible to the back end")

endmodule

`default_nettype wire

// File: hdl/ttqs_back.sv
// ----------------------------------------------------------------------------
// Timed tone queue scheduler back end
// Runs the tone ring queue, computes end times and amplitudes, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module ttqs_back #(
	parameter int QUEUE_DEPTH = ttqs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [ttqs_pkg::TICK_W-1:0] ticks_per_ms,
	input  wire logic [ttqs_pkg::GAIN_W-1:0] volume_gain,
	input  wire logic                        q_valid,
	output logic                             q_ready,
	input  wire ttqs_pkg::item_t             q_item,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output logic [1:0]                       command,
	output logic [ttqs_pkg::FREQ_W-1:0]      out_freq,
	output logic [ttqs_pkg::AMP_W-1:0]       amplitude
);

	import ttqs_pkg::*;

	`include "timed_tone_queue_scheduler_top_assert.svh"

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LastIdx   = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MUL  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic              playing_q;
	logic [TIME_W-1:0] end_time_q;
	logic [TIME_W-1:0] start_q;
	logic [SPAN_W-1:0] span_q;
	logic [PROD_W-1:0] prod_q;
	logic [FREQ_W-1:0] freq_q;
	logic              res_valid_q;
	cmd_t              res_cmd_q;
	logic [FREQ_W-1:0] res_freq_q;
	logic [AMP_W-1:0]  res_amp_q;

	tone_t             rd_tone;
	logic [AW-1:0]     next_head;
	logic [AW-1:0]     next_tail;
	logic              out_free;
	logic              pop;
	logic              full;
	logic              svc;
	logic              svc_start;
	logic              svc_adv;
	logic              adv_close;
	logic              svc_read;
	logic              do_close;
	logic              do_drop;
	logic              enq_wr;
	logic              tone_fire;
	logic [TIME_W-1:0] end_sum;
	logic [AMP_W-1:0]  amp_sat;

	assign next_head = (head_q == LastIdx) ? '0 : head_q + AW'(1);
	assign next_tail = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
	assign out_free  = !res_valid_q || result_ready;
	assign q_ready   = (state_q == S_IDLE) && out_free;
	assign pop       = q_valid && q_ready;
	assign full      = (count_q == FullCount);
	assign svc       = pop && (q_item.op == OP_SVC) && (count_q != '0);
	assign svc_start = svc && !playing_q;
	assign svc_adv   = svc && playing_q && !(q_item.now < end_time_q);
	assign adv_close = svc_adv && (count_q == CW'(1));
	assign svc_read  = svc_start || (svc_adv && !adv_close);
	assign do_close  = (pop && (q_item.op == OP_SVC) && (count_q == '0)) || adv_close;
	assign do_drop   = pop && (q_item.op == OP_ENQ) && full;
	assign enq_wr    = pop && (q_item.op == OP_ENQ) && !full;
	assign tone_fire = (state_q == S_OUT) && out_free;
	assign end_sum   = start_q + TIME_W'(span_q);
	assign amp_sat   = prod_q[PROD_W-1] ? AMP_MAX : prod_q[AMP_W-1:0];

	ttqs_ram #(
		.WIDTH ($bits(tone_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (enq_wr),
		.waddr (tail_q),
		.wdata (q_item.tone),
		.re    (svc_read),
		.raddr (playing_q ? next_head : head_q),
		.rdata (rd_tone)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			playing_q   <= 1'b0;
			end_time_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (q_item.op)
							OP_ENQ: begin
								if (!full) begin
									tail_q  <= next_tail;
									count_q <= count_q + CW'(1);
								end
							end
							OP_CLR: begin
								head_q    <= '0;
								tail_q    <= '0;
								count_q   <= '0;
								playing_q <= 1'b0;
							end
							OP_SVC: begin
								if (svc_adv) begin
									head_q    <= next_head;
									count_q   <= count_q - CW'(1);
									playing_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
						if (svc_read) begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q    <= S_IDLE;
						playing_q  <= 1'b1;
						end_time_q <= end_sum;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (do_close || do_drop || tone_fire) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (svc_read) begin
			start_q <= playing_q ? end_time_q : q_item.now;
		end
		if (state_q == S_MUL) begin
			span_q <= SPAN_W'(rd_tone.ms) * SPAN_W'(ticks_per_ms);
			prod_q <= PROD_W'(rd_tone.vol) * PROD_W'(volume_gain);
			freq_q <= rd_tone.freq;
		end
		if (do_close || do_drop) begin
			res_cmd_q  <= do_drop ? CMD_DROP : CMD_CLOSE;
			res_freq_q <= '0;
			res_amp_q  <= '0;
		end else if (tone_fire) begin
			if (freq_q != '0) begin
				res_cmd_q  <= CMD_START;
				res_freq_q <= freq_q;
				res_amp_q  <= amp_sat;
			end else begin
				res_cmd_q  <= CMD_PAUSE;
				res_freq_q <= '0;
				res_amp_q  <= '0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign command      = res_cmd_q;
	assign out_freq     = res_freq_q;
	assign amplitude    = res_amp_q;

	`TTQS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FullCount,
		"back: entry count exceeds the queue depth")
	`TTQS_ASSERT_IMP(a_playing_nonempty, clk, arst_n, playing_q, count_q != '0,
		"back: a tone plays from an empty queue")
	`TTQS_ASSERT_NXT(a_tone_result, clk, arst_n, tone_fire,
		res_valid_q && playing_q && (state_q == S_IDLE),
		"back: a started tone did not produce a result")
	`TTQS_ASSERT_IMP(a_wr_when_free, clk, arst_n, (do_close || do_drop), out_free,
		"back: a result overwrote an untaken beat")

endmodule

`default_nettype wire

// File: hdl/timed_tone_queue_scheduler_top.sv
// Path: beats pass the front-end queue to the back end, which applies enqueue and clear and
// registers close and drop results; a started tone goes through memory read, S_MUL and S_OUT.
// Throughput: one beat per cycle for enqueue and clear while the back end idles, output free;
// a service that reads the queue memory occupies the back end (memory read, multiply, end-time add).
// Reset: arst_n clears the queue indices, count, play state and queues; config returns to
// 1000 ticks per ms and gain 160. The tone memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Timed tone queue scheduler top level
// Configuration registers, front-end decode queue and back-end tone sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_tone_queue_scheduler_top #(
	parameter int QUEUE_DEPTH = ttqs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [1:0]                    mode,
	input  wire logic [ttqs_pkg::FREQ_W-1:0]   tone_freq,
	input  wire logic [ttqs_pkg::MS_W-1:0]     tone_ms,
	input  wire logic [ttqs_pkg::VOL_W-1:0]    tone_vol,
	input  wire logic [ttqs_pkg::TIME_W-1:0]   now,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [1:0]                         command,
	output logic [ttqs_pkg::FREQ_W-1:0]        out_freq,
	output logic [ttqs_pkg::AMP_W-1:0]         amplitude,
	input  wire logic                          wr_en,
	input  wire logic                          wr_index,
	input  wire logic [ttqs_pkg::TICK_W-1:0]   wr_data
);

	import ttqs_pkg::*;

	logic [TICK_W-1:0] ticks_q;
	logic [GAIN_W-1:0] gain_q;
	logic              q_valid;
	logic              q_ready;
	item_t             q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
			gain_q  <= GAIN_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TICKS: ticks_q <= wr_data;
				REG_GAIN:  gain_q  <= wr_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ttqs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.tone_freq  (tone_freq),
		.tone_ms    (tone_ms),
		.tone_vol   (tone_vol),
		.now        (now),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item)
	);

	ttqs_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ticks_per_ms (ticks_q),
		.volume_gain  (gain_q),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.command      (command),
		.out_freq     (out_freq),
		.amplitude    (amplitude)
	);

endmodule

`default_nettype wire

// File: tb/timed_tone_queue_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// Timed tone queue scheduler testbench
// Drives enqueue, service, clear and unused-mode beats with random bursts and gaps while
// the result side stalls on its own pattern. A scoreboard keeps its own copy
// of the tone queue and play state, predicts each command and compares every
// result beat field by field. Runs through several gain and tick settings,
// a directed opening and playlist-shaped random traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_tone_queue_scheduler_top_tb;

	import ttqs_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		cmd_t              cmd;
		logic [FREQ_W-1:0] freq;
		logic [AMP_W-1:0]  amp;
	} cmd_beat_t;

	class tone_command_board;
		tone_t             tones [DEPTH];
		int unsigned       head_pos;
		int unsigned       tail_pos;
		int unsigned       tone_count;
		bit                playing;
		logic [TIME_W-1:0] end_time;
		logic [TICK_W-1:0] ticks_per_ms;
		logic [GAIN_W-1:0] gain;
		cmd_beat_t         due_cmds [$];
		int                errors;

		function new();
			head_pos = 0;
			tail_pos = 0;
			tone_count = 0;
			playing = 1'b0;
			end_time = '0;
			ticks_per_ms = TICKS_RESET;
			gain = GAIN_RESET;
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [TICK_W-1:0] val);
			if (idx == REG_TICKS) begin
				ticks_per_ms = val;
			end else begin
				gain = val[GAIN_W-1:0];
			end
		endfunction

		function void push_cmd(cmd_t c, logic [FREQ_W-1:0] f, logic [AMP_W-1:0] a);
			cmd_beat_t b;
			b.cmd = c;
			b.freq = f;
			b.amp = a;
			due_cmds.push_back(b);
		endfunction

		function void start_head(logic [TIME_W-1:0] t0);
			tone_t             t;
			logic [SPAN_W-1:0] span;
			logic [PROD_W-1:0] prod;
			t = tones[head_pos];
			span = SPAN_W'(t.ms) * SPAN_W'(ticks_per_ms);
			end_time = t0 + TIME_W'(span);
			playing = 1'b1;
			if (t.freq == '0) begin
				push_cmd(CMD_PAUSE, '0, '0);
			end else begin
				prod = PROD_W'(t.vol) * PROD_W'(gain);
				push_cmd(CMD_START, t.freq,
					(prod > PROD_W'(AMP_MAX)) ? AMP_MAX : prod[AMP_W-1:0]);
			end
		endfunction

		function void note_beat(logic [1:0] m, tone_t t, logic [TIME_W-1:0] ts);
			case (m)
				OP_ENQ: begin
					if (tone_count >= DEPTH) begin
						push_cmd(CMD_DROP, '0, '0);
					end else begin
						tones[tail_pos] = t;
						tail_pos = (tail_pos + 1) % DEPTH;
						tone_count++;
					end
				end
				OP_CLR: begin
					head_pos = 0;
					tail_pos = 0;
					tone_count = 0;
					playing = 1'b0;
				end
				OP_SVC: begin
					if (tone_count == 0) begin
						push_cmd(CMD_CLOSE, '0, '0);
					end else if (!playing) begin
						start_head(ts);
					end else if (ts >= end_time) begin
						head_pos = (head_pos + 1) % DEPTH;
						tone_count--;
						playing = 1'b0;
						if (tone_count == 0) begin
							push_cmd(CMD_CLOSE, '0, '0);
						end else begin
							start_head(end_time);
						end
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_command(logic [1:0] c, logic [FREQ_W-1:0] f,
				logic [AMP_W-1:0] a);
			cmd_beat_t want;
			if (due_cmds.size() == 0) begin
				$display("%0t: unexpected beat, command %0d freq %0d amplitude %0d",
					$time, c, f, a);
				errors++;
			end else begin
				want = due_cmds.pop_front();
				if (c !== want.cmd) begin
					$display("%0t: command mismatch, expected %0d, actual %0d",
						$time, want.cmd, c);
					errors++;
				end
				if (f !== want.freq) begin
					$display("%0t: out_freq mismatch, expected %0d, actual %0d",
						$time, want.freq, f);
					errors++;
				end
				if (a !== want.amp) begin
					$display("%0t: amplitude mismatch, expected %0d, actual %0d",
						$time, want.amp, a);
					errors++;
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	logic [1:0]        mode = '0;
	logic [FREQ_W-1:0] tone_freq = '0;
	logic [MS_W-1:0]   tone_ms = '0;
	logic [VOL_W-1:0]  tone_vol = '0;
	logic [TIME_W-1:0] now = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic [1:0]        command;
	logic [FREQ_W-1:0] out_freq;
	logic [AMP_W-1:0]  amplitude;
	logic              wr_en = 1'b0;
	logic              wr_index = 1'b0;
	logic [TICK_W-1:0] wr_data = '0;

	tone_command_board sb = new();

	int burst_left = 0;
	int items_sent = 0;
	int rx_style = 0;
	int style_left = 0;
	int stall_left = 0;

	timed_tone_queue_scheduler_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.mode         (mode),
		.tone_freq    (tone_freq),
		.tone_ms      (tone_ms),
		.tone_vol     (tone_vol),
		.now          (now),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.command      (command),
		.out_freq     (out_freq),
		.amplitude    (amplitude),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (style_left == 0) begin
			rx_style = $urandom_range(0, 2);
			style_left = $urandom_range(50, 400);
		end
		style_left--;
		if (stall_left != 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			case (rx_style)
				1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
				2: if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(5, 30);
				default: begin
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			sb.check_command(command, out_freq, amplitude);
		end
	end

	function automatic logic [TIME_W-1:0] rand_now();
		return TIME_W'({$urandom, $urandom});
	endfunction

	function automatic tone_t mk_tone(logic [FREQ_W-1:0] f, logic [MS_W-1:0] ms,
			logic [VOL_W-1:0] v);
		tone_t t;
		t.freq = f;
		t.ms = ms;
		t.vol = v;
		return t;
	endfunction

	function automatic tone_t rand_tone();
		tone_t t;
		case ($urandom_range(0, 7))
			0: t.freq = '0;
			1: t.freq = '1;
			default: t.freq = FREQ_W'($urandom);
		endcase
		t.ms = ($urandom_range(0, 7) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(0, 20));
		t.vol = VOL_W'($urandom_range(0, 127));
		return t;
	endfunction

	// Service timestamps are placed around the predicted end of the playing tone, or at random when none plays.
	function automatic logic [TIME_W-1:0] pick_now();
		if (!sb.playing) begin
			if ($urandom_range(0, 3) == 0) begin
				return TIME_W'({TIME_W{1'b1}}) - TIME_W'($urandom_range(0, 100));
			end
			return rand_now();
		end
		case ($urandom_range(0, 9))
			0: return rand_now();
			1, 2: return sb.end_time - TIME_W'($urandom_range(1, 50));
			3: return sb.end_time;
			9: return sb.end_time + TIME_W'($urandom);
			default: return sb.end_time + TIME_W'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic send_item(input logic [1:0] m, input tone_t t, input logic [TIME_W-1:0] ts);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		mode <= m;
		tone_freq <= t.freq;
		tone_ms <= t.ms;
		tone_vol <= t.vol;
		now <= ts;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		sb.note_beat(m, t, ts);
		if (m != MODE_UNUSED) items_sent++;
		@(negedge clk);
	endtask

	task automatic send_tone();
		send_item(OP_ENQ, rand_tone(), rand_now());
	endtask

	task automatic send_service();
		send_item(OP_SVC, rand_tone(), pick_now());
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		burst_left = 0;
		while (sb.due_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [TICK_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		sb.set_reg(idx, val);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [TICK_W-1:0] ticks, input logic [GAIN_W-1:0] g);
		write_reg(REG_TICKS, ticks);
		write_reg(REG_GAIN, TICK_W'(g));
	endtask

	task automatic run_directed();
		send_item(OP_SVC, mk_tone('0, '0, '0), '0);
		send_item(OP_ENQ, mk_tone('1, '1, '1), '1);
		send_item(OP_ENQ, mk_tone('0, 16'd1, '0), '0);
		send_item(OP_ENQ, mk_tone(16'd1, '0, 7'd100), '0);
		send_item(MODE_UNUSED, mk_tone('1, '1, '1), '1);
		send_item(OP_SVC, mk_tone('0, '0, '0), TIME_W'({TIME_W{1'b1}}) - TIME_W'(5));
		send_item(OP_SVC, mk_tone('0, '0, '0), '0);
		send_item(OP_SVC, mk_tone('0, '0, '0), sb.end_time - TIME_W'(1));
		send_item(OP_SVC, mk_tone('0, '0, '0), sb.end_time);
		send_item(OP_SVC, mk_tone('0, '0, '0), sb.end_time + TIME_W'(12345));
		send_item(OP_SVC, mk_tone('0, '0, '0), sb.end_time);
		send_item(OP_SVC, mk_tone('0, '0, '0), 48'h5555_5555_5555);
		send_item(OP_ENQ, mk_tone(16'hAAAA, 16'h5555, 7'h55), 48'hAAAA_AAAA_AAAA);
		send_item(OP_CLR, mk_tone(16'h5555, 16'hAAAA, 7'h2A), 48'h5555_5555_5555);
		send_item(OP_SVC, mk_tone('0, '0, '0), '0);
		send_item(OP_ENQ, mk_tone(16'h5555, 16'hAAAA, 7'h2A), '0);
		send_item(OP_SVC, mk_tone('0, '0, '0), 48'hAAAA_AAAA_AAAA);
		send_item(OP_SVC, mk_tone('0, '0, '0), 48'h5555_5555_5555);
		send_item(OP_ENQ, mk_tone(16'h1234, 16'd3, 7'd50), '0);
		send_item(OP_CLR, mk_tone('1, '1, '1), '1);
		send_item(OP_SVC, mk_tone('0, '0, '0), '1);
	endtask

	task automatic run_playlist();
		int n_tones;
		int guard;
		if ($urandom_range(0, 3) == 0) send_item(OP_CLR, rand_tone(), rand_now());
		n_tones = $urandom_range(1, 8);
		repeat (n_tones) send_tone();
		guard = 0;
		while (sb.tone_count != 0 && guard < 4 * n_tones + 8) begin
			if ($urandom_range(0, 9) == 0) begin
				send_tone();
			end else begin
				send_service();
			end
			guard++;
		end
		send_service();
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 4)) begin
			send_item(2'($urandom_range(0, 3)), rand_tone(),
				($urandom_range(0, 1) == 0) ? rand_now() : pick_now());
		end
	endtask

	task automatic run_random(input int n_items);
		int goal;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			if ($urandom_range(0, 4) == 0) begin
				run_noise();
			end else begin
				run_playlist();
			end
		end
	endtask

	initial begin
		logic [TICK_W-1:0] ticks_set [5];
		logic [GAIN_W-1:0] gain_set [5];
		ticks_set[0] = TICK_W'(1);
		gain_set[0] = GAIN_W'(327);
		ticks_set[1] = '1;
		gain_set[1] = '1;
		ticks_set[2] = '0;
		gain_set[2] = '0;
		ticks_set[3] = TICK_W'($urandom_range(1, 5000));
		gain_set[3] = GAIN_W'($urandom_range(0, 511));
		ticks_set[4] = TICK_W'(3);
		gain_set[4] = GAIN_W'(1);
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		run_random(ITEMS_PER_PHASE);
		drain();
		for (int i = 0; i < 5; i++) begin
			set_config(ticks_set[i], gain_set[i]);
			run_random(ITEMS_PER_PHASE);
			drain();
		end
		if (sb.errors == 0 && sb.due_cmds.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
